FILE: design/ffa_pkg.sv
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffa_pkg;

    // Fixed field widths.
    localparam int SZ_W    = 13;
    localparam int CFG_W   = 13;
    localparam int REQ_W   = 12;
    localparam int ADDR_W  = 16;
    localparam int DADDR_W = 12;
    localparam int STAT_W  = 2;

    // Allocator constants.
    localparam int SPLIT_SLACK = 8;
    localparam int POOL_MIN    = 16;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

    // One block header as stored in the header memory.
    typedef struct packed {
        logic            free;
        logic [SZ_W-1:0] size;
    } mem_word_t;

    // Access request from the sequencer to the header memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        mem_word_t         wdata;
    } mem_req_t;

endpackage
`default_nettype wire

FILE: design/ffa_if.sv
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffa_req_if
    import ffa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [REQ_W-1:0]   req_size;
    logic [ADDR_W-1:0]  free_addr;

    modport source (output valid, output req_type, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input req_type, input req_size, input free_addr,
                    output ready);
endinterface

interface ffa_rsp_if
    import ffa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [DADDR_W-1:0] data_addr;

    modport source (output valid, output status, output data_addr, input ready);
    modport sink   (input valid, input status, input data_addr, output ready);
endinterface
`default_nettype wire

FILE: design/ffa_mem.sv
// Block header memory: one write port and one registered read port.
`default_nettype none
module ffa_mem
    import ffa_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  wire logic clk,
    input  wire mem_req_t mreq,
    output mem_word_t rdata
);
    localparam int AW = $clog2(DEPTH);

    mem_word_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr[AW-1:0]] <= mreq.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (mreq.rd_en)
        begin
            rdata <= mem[mreq.rd_addr[AW-1:0]];
        end
    end
endmodule
`default_nettype wire

FILE: design/ffa_ctrl.sv
// Sequencer and datapath that walk the block chain for allocate and free.
`default_nettype none
module ffa_ctrl
    import ffa_pkg::*;
#(
    parameter int MAX_POOL_BYTES = 4096,
    parameter int HDR_BYTES      = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    ffa_req_if.sink               req,
    ffa_rsp_if.source             rsp,
    output mem_req_t              mreq,
    input  wire mem_word_t        rdata
);
    // Offset width, value width with headroom for sums, compare width.
    localparam int PW = $clog2(MAX_POOL_BYTES + 1);
    localparam int VW = ((PW > SZ_W) ? PW : SZ_W) + 1;
    localparam int CW = (VW > ADDR_W) ? VW : ADDR_W;
    localparam int RESET_POOL = (4096 > MAX_POOL_BYTES) ? MAX_POOL_BYTES : 4096;

    localparam logic [VW-1:0] HDR_V   = VW'(HDR_BYTES);
    localparam logic [VW-1:0] SPLIT_V = VW'(HDR_BYTES + SPLIT_SLACK);

    // State codes.
    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_RD    = 4'd2;
    localparam logic [3:0] S_A_EVAL  = 4'd3;
    localparam logic [3:0] S_A_DEC   = 4'd4;
    localparam logic [3:0] S_A_SPLIT = 4'd5;
    localparam logic [3:0] S_F_RD    = 4'd6;
    localparam logic [3:0] S_F_MARK  = 4'd7;
    localparam logic [3:0] S_F_SIZE  = 4'd8;
    localparam logic [3:0] S_F_CHK   = 4'd9;
    localparam logic [3:0] S_F_NEVAL = 4'd10;
    localparam logic [3:0] S_F_SUM   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [PW-1:0]      pool_reg, pool_next;
    logic [PW-1:0]      o_reg, o_next;
    logic [PW-1:0]      nx_reg, nx_next;
    logic [VW-1:0]      s_reg, s_next;
    logic [VW-1:0]      ns_reg, ns_next;
    logic [VW-1:0]      room_reg, room_next;
    logic [SZ_W-1:0]    raw_reg, raw_next;
    logic               free_reg, free_next;
    logic [REQ_W-1:0]   rsize_reg, rsize_next;
    logic [STAT_W-1:0]  res_stat_reg, res_stat_next;
    logic [DADDR_W-1:0] res_addr_reg, res_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [DADDR_W-1:0] out_addr_reg, out_addr_next;

    // Datapath terms used by the states.
    logic [VW-1:0] pool_v, o_v, room_o, room_nx, sz_v, pay, req_v, nx_v, sum;
    logic [CW-1:0] fa_c;
    logic          fit, split;

    // Saturated pool size from the configuration word.
    function automatic logic [PW-1:0] clamp_pool(input logic [CFG_W-1:0] v);
        logic [VW-1:0] w;
        w = VW'(v);
        if (w < VW'(POOL_MIN))
        begin
            return PW'(POOL_MIN);
        end
        else if (w > VW'(MAX_POOL_BYTES))
        begin
            return PW'(MAX_POOL_BYTES);
        end
        return PW'(w);
    endfunction

    always_comb
    begin
        pool_v  = VW'(pool_reg);
        o_v     = VW'(o_reg);
        room_o  = pool_v - o_v;
        room_nx = pool_v - VW'(nx_reg);
        sz_v    = VW'(rdata.size);
        pay     = s_reg - HDR_V;
        req_v   = VW'(rsize_reg);
        nx_v    = o_v + s_reg;
        sum     = s_reg + ns_reg;
        fa_c    = CW'(req.free_addr);
        fit     = free_reg && (s_reg > HDR_V) && (pay > req_v);
        split   = (pay - req_v) > SPLIT_V;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        o_next         = o_reg;
        nx_next        = nx_reg;
        s_next         = s_reg;
        ns_next        = ns_reg;
        room_next      = room_reg;
        raw_next       = raw_reg;
        free_next      = free_reg;
        rsize_next     = rsize_reg;
        res_stat_next  = res_stat_reg;
        res_addr_next  = res_addr_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_addr_next  = out_addr_reg;
        mreq           = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // One free block covering the whole pool.
                mreq.wr_en      = 1'b1;
                mreq.wr_addr    = '0;
                mreq.wdata.free = 1'b1;
                mreq.wdata.size = SZ_W'(pool_reg);
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_stat_next = ST_OK;
                    res_addr_next = '0;
                    rsize_next    = req.req_size;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        o_next     = '0;
                        state_next = S_A_RD;
                    end
                    else if (fa_c < CW'(HDR_BYTES) || fa_c >= CW'(pool_reg))
                    begin
                        res_stat_next = ST_IGNORED;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        o_next     = PW'(fa_c - CW'(HDR_BYTES));
                        state_next = S_F_RD;
                    end
                end
            end
            S_A_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = ADDR_W'(o_reg);
                state_next   = S_A_EVAL;
            end
            S_A_EVAL:
            begin
                raw_next   = rdata.size;
                free_next  = rdata.free;
                s_next     = (sz_v > room_o) ? room_o : sz_v;
                state_next = S_A_DEC;
            end
            S_A_DEC:
            begin
                if (fit)
                begin
                    res_addr_next = DADDR_W'(o_v + HDR_V);
                    if (split)
                    begin
                        // Leftover becomes a free block behind the taken one.
                        mreq.wr_en      = 1'b1;
                        mreq.wr_addr    = ADDR_W'(o_v + HDR_V + req_v);
                        mreq.wdata.free = 1'b1;
                        mreq.wdata.size = SZ_W'(pay - req_v);
                        state_next      = S_A_SPLIT;
                    end
                    else
                    begin
                        mreq.wr_en      = 1'b1;
                        mreq.wr_addr    = ADDR_W'(o_reg);
                        mreq.wdata.free = 1'b0;
                        mreq.wdata.size = raw_reg;
                        state_next      = S_DONE;
                    end
                end
                else if (s_reg == '0 || nx_v >= pool_v)
                begin
                    res_stat_next = ST_NOFIT;
                    state_next    = S_DONE;
                end
                else
                begin
                    o_next     = PW'(nx_v);
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                mreq.wr_en      = 1'b1;
                mreq.wr_addr    = ADDR_W'(o_reg);
                mreq.wdata.free = 1'b0;
                mreq.wdata.size = SZ_W'(HDR_V + req_v);
                state_next      = S_DONE;
            end
            S_F_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = ADDR_W'(o_reg);
                state_next   = S_F_MARK;
            end
            S_F_MARK:
            begin
                // Mark the header free, size as stored.
                mreq.wr_en      = 1'b1;
                mreq.wr_addr    = ADDR_W'(o_reg);
                mreq.wdata.free = 1'b1;
                mreq.wdata.size = rdata.size;
                raw_next        = rdata.size;
                state_next      = S_F_SIZE;
            end
            S_F_SIZE:
            begin
                s_next     = (VW'(raw_reg) > room_o) ? room_o : VW'(raw_reg);
                room_next  = room_o;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (s_reg == '0 || nx_v >= pool_v)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = ADDR_W'(nx_v);
                    nx_next      = PW'(nx_v);
                    state_next   = S_F_NEVAL;
                end
            end
            S_F_NEVAL:
            begin
                ns_next    = (sz_v > room_nx) ? room_nx : sz_v;
                state_next = rdata.free ? S_F_SUM : S_DONE;
            end
            S_F_SUM:
            begin
                if (ns_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Absorb the following free block.
                    mreq.wr_en      = 1'b1;
                    mreq.wr_addr    = ADDR_W'(o_reg);
                    mreq.wdata.free = 1'b1;
                    mreq.wdata.size = SZ_W'((sum > room_reg) ? room_reg : sum);
                    raw_next        = SZ_W'((sum > room_reg) ? room_reg : sum);
                    state_next      = S_F_SIZE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_addr_next  = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // A configuration write rebuilds the pool.
        if (cfg_we)
        begin
            pool_next  = clamp_pool(cfg_wdata);
            state_next = S_INIT;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pool_reg      <= PW'(RESET_POOL);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        o_reg        <= o_next;
        nx_reg       <= nx_next;
        s_reg        <= s_next;
        ns_reg       <= ns_next;
        room_reg     <= room_next;
        raw_reg      <= raw_next;
        free_reg     <= free_next;
        rsize_reg    <= rsize_next;
        res_stat_reg <= res_stat_next;
        res_addr_reg <= res_addr_next;
        out_stat_reg <= out_stat_next;
        out_addr_reg <= out_addr_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_stat_reg;
    assign rsp.data_addr = out_addr_reg;

    // The memory is never written while waiting for a request.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mreq.wr_en)
        else $error("header write while idle");

    // Every header write lands inside the pool.
    a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.wr_en |-> (VW'(mreq.wr_addr) < VW'(pool_reg)))
        else $error("header write beyond pool end");

    // A failed request never reports a payload offset.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.data_addr == '0))
        else $error("offset reported on failure");

    // An accepted request moves the sequencer out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !cfg_we) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // A configuration write always rebuilds the first header.
    a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == S_INIT))
        else $error("configuration write did not reinitialize the pool");
endmodule
`default_nettype wire

FILE: design/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator.
// Allocate: each header walked is read and checked; a split writes a second header. Free:
// the header is read and marked free, then each following free block is read and merged;
// an ignored free skips the walk. Headers are read one at a time from a single memory port.
// One request is in work at a time; its result word waits in an output register until taken.
// Reset and each pool_size write rebuild the first header; others keep data.
`default_nettype none
module first_fit_block_allocator_unit
    import ffa_pkg::*;
#(
    parameter int MAX_POOL_BYTES = 4096,
    parameter int HDR_BYTES      = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    ffa_req_if.sink               req,
    ffa_rsp_if.source             rsp
);
    mem_req_t  mreq;
    mem_word_t rdata;

    // Walk sequencer.
    ffa_ctrl #(
        .MAX_POOL_BYTES (MAX_POOL_BYTES),
        .HDR_BYTES      (HDR_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    // Header store indexed by byte offset.
    ffa_mem #(
        .DEPTH (MAX_POOL_BYTES)
    ) u_mem (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );
endmodule
`default_nettype wire
